/* rtl/artvs_pkg.sv */
// Shared types and constants for the AR texture vibration synthesizer.
// Used by the top level, the shared MAC unit and the port checker.
package artvs_pkg;

  localparam int OUT_W       = 32;
  localparam int DRIVE_W     = 16;
  localparam int COEF_W      = 18;
  localparam int STD_W       = 16;
  localparam int GAIN_W      = 16;
  localparam int NOISE_W     = 16;
  localparam int TAPC_W      = 5;
  localparam int TAPIDX_W    = 4;
  localparam int CMD_W       = 2;
  localparam int PROD_W      = OUT_W + COEF_W;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam int EXC_SHIFT   = 8;
  localparam int Y_SHIFT     = 12;
  localparam int DRIVE_SHIFT = 13;
  localparam int DRIVE_LIMIT = 20480;
  localparam int STD_MAX     = 65535;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd2048;

  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COEF   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STD    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN = 1'b1;

  typedef struct packed {
    logic mul_en;   // load the product register
    logic acc_clr;  // clear the accumulator
    logic acc_exc;  // add the product as excitation, scaled up
    logic acc_sub;  // subtract the product as an AR term
  } mac_ctrl_t;

endpackage

/* rtl/artvs_mac.sv */
// Shared signed multiplier with a registered product and a wide accumulator.
// Depends on artvs_pkg for widths and the control struct.
module artvs_mac import artvs_pkg::*; #(
  parameter int ACC_W = 55
) (
  input  logic                     clk,
  input  mac_ctrl_t                ctrl,
  input  logic signed [OUT_W-1:0]  op_a,
  input  logic signed [COEF_W-1:0] op_b,
  output logic signed [PROD_W-1:0] prod,
  output logic signed [ACC_W-1:0]  acc
);

  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  prod_ext;

  always_comb begin
    prod_nxt = prod_r;
    if (ctrl.mul_en) begin
      prod_nxt = PROD_W'(op_a) * PROD_W'(op_b);
    end
  end

  always_comb begin
    prod_ext = ACC_W'(prod_r);
    acc_nxt  = acc_r;
    if (ctrl.acc_clr) begin
      acc_nxt = '0;
    end else if (ctrl.acc_exc) begin
      acc_nxt = acc_r + (prod_ext <<< EXC_SHIFT);
    end else if (ctrl.acc_sub) begin
      acc_nxt = acc_r - prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

/* rtl/ar_texture_vibration_synth.sv */
// AR (all-pole) noise synthesizer for haptic texture vibration.
// Depends on artvs_pkg and the shared MAC unit artvs_mac.
//
// Input channel (in_valid / in_stall): one transfer per item. A sample item
// (command 0) produces one result; coefficient and standard deviation writes
// (commands 1 and 2) update the selected bank and produce nothing.
// Command 3 is dropped.
// Result channel (out_valid / out_stall): filter output in Q16.16 and the
// gained drive value in Q5.11, clamped to +-10.0.
// Configuration: cfg_wr_en writes tap_count (index 0) or output_gain
// (index 1); the user must write only while idle, unchecked by the block.
//
// A sample walks all MAX_TAPS history entries through one multiplier, one
// entry per cycle, through states EXC, TAP, LAST, SAT, GAIN and DRV;
// out_valid rises when DRV hands the result to the output register, and no
// new item is taken until the block is back in IDLE. The history ring and
// the coefficient memory port set that pace. Writes leave the block idle.
// If the receiver stalls, the finished result waits in the output register;
// a following sample is computed and then held until that register frees.
// Reset clears history, coefficients, std devs and registers; gain = 2048.
module ar_texture_vibration_synth import artvs_pkg::*; #(
  parameter int MAX_TAPS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [CMD_W-1:0]           in_command,
  input  logic                       in_bank,
  input  logic [TAPIDX_W-1:0]        in_tap_index,
  input  logic signed [COEF_W-1:0]   in_load_value,
  input  logic signed [NOISE_W-1:0]  in_noise_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [OUT_W-1:0]    out_filter_output,
  output logic signed [DRIVE_W-1:0]  out_drive_value
);

  localparam int DEPTH = 2 * MAX_TAPS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int ACC_W = PROD_W + $clog2(MAX_TAPS + 1);
  localparam int YW    = ACC_W - Y_SHIFT;
  localparam int DW    = PROD_W - DRIVE_SHIFT;
  localparam logic [IW-1:0] LAST_TAP = IW'(MAX_TAPS - 1);
  localparam logic signed [DW-1:0] D_HI = DW'(DRIVE_LIMIT);
  localparam logic signed [DW-1:0] D_LO = DW'(-DRIVE_LIMIT);

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXC, ST_TAP, ST_LAST, ST_SAT, ST_GAIN, ST_DRV
  } state_t;

  state_t state_r, state_nxt;
  logic [IW-1:0]              cnt_r, cnt_nxt;
  logic                       bank_r, bank_nxt;
  logic signed [NOISE_W-1:0]  noise_r, noise_nxt;
  logic [TAPC_W-1:0]          tap_count_r, tap_count_nxt;
  logic [GAIN_W-1:0]          gain_r, gain_nxt;
  logic [STD_W-1:0]           std_r [2];
  logic [STD_W-1:0]           std_nxt [2];
  logic signed [OUT_W-1:0]    hist_r [MAX_TAPS];
  logic signed [OUT_W-1:0]    hist_nxt [MAX_TAPS];
  logic signed [OUT_W-1:0]    y_r, y_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0]    out_y_r, out_y_nxt;
  logic signed [DRIVE_W-1:0]  out_drive_r, out_drive_nxt;

  // Coefficient memory with per-entry valid bits so reset reads as zero.
  logic signed [COEF_W-1:0]   coef_mem [DEPTH];
  logic [DEPTH-1:0]           coef_vld_r;
  logic signed [COEF_W-1:0]   coef_rd_r;
  logic                       coef_vld_rd_r;

  logic                       accept;
  logic                       tap_live;
  logic                       coef_wr;
  logic [AW-1:0]              wr_addr;
  logic [IW-1:0]              rd_tap;
  logic [AW-1:0]              rd_addr;
  logic signed [COEF_W-1:0]   coef_op;
  logic [STD_W-1:0]           std_load;
  logic signed [YW-1:0]       acc_sh;
  logic signed [OUT_W-1:0]    y_sat;
  logic signed [DW-1:0]       d_sh;
  logic signed [DRIVE_W-1:0]  drive_clamp;

  mac_ctrl_t                  mac_ctrl;
  logic signed [OUT_W-1:0]    mac_a;
  logic signed [COEF_W-1:0]   mac_b;
  logic signed [PROD_W-1:0]   mac_prod;
  logic signed [ACC_W-1:0]    mac_acc;

  artvs_mac #(.ACC_W(ACC_W)) u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (mac_a),
    .op_b (mac_b),
    .prod (mac_prod),
    .acc  (mac_acc)
  );

  assign in_stall          = (state_r != ST_IDLE);
  assign accept            = in_valid && !in_stall;
  assign out_valid         = out_valid_r;
  assign out_filter_output = out_y_r;
  assign out_drive_value   = out_drive_r;

  // Entries at or above the tap count take no part and are cleared.
  assign tap_live = (32'(cnt_r) < 32'(tap_count_r));
  assign coef_op  = (coef_vld_rd_r && tap_live) ? coef_rd_r : '0;

  assign coef_wr = accept && (in_command == CMD_COEF) && (32'(in_tap_index) < MAX_TAPS);
  assign wr_addr = AW'(in_tap_index) + (in_bank ? AW'(MAX_TAPS) : AW'(0));
  assign rd_tap  = (state_r == ST_TAP && cnt_r != LAST_TAP) ? cnt_r + IW'(1) : '0;
  assign rd_addr = AW'(rd_tap) + (bank_r ? AW'(MAX_TAPS) : AW'(0));

  always_comb begin
    if (in_load_value < 0) begin
      std_load = '0;
    end else if (32'(in_load_value) > STD_MAX) begin
      std_load = '1;
    end else begin
      std_load = in_load_value[STD_W-1:0];
    end
  end

  // Floor shift is an arithmetic right shift; then saturate to 32 bits.
  always_comb begin
    acc_sh = mac_acc[ACC_W-1:Y_SHIFT];
    if ((&acc_sh[YW-1:OUT_W-1]) || !(|acc_sh[YW-1:OUT_W-1])) begin
      y_sat = acc_sh[OUT_W-1:0];
    end else if (acc_sh[YW-1]) begin
      y_sat = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_comb begin
    d_sh = mac_prod[PROD_W-1:DRIVE_SHIFT];
    if (d_sh > D_HI) begin
      drive_clamp = DRIVE_W'(DRIVE_LIMIT);
    end else if (d_sh < D_LO) begin
      drive_clamp = DRIVE_W'(-DRIVE_LIMIT);
    end else begin
      drive_clamp = d_sh[DRIVE_W-1:0];
    end
  end

  always_comb begin
    mac_ctrl = '0;
    mac_a    = hist_r[0];
    mac_b    = coef_op;
    case (state_r)
      ST_IDLE: begin
        mac_ctrl.acc_clr = accept;
      end
      ST_EXC: begin
        mac_ctrl.mul_en = 1'b1;
        mac_a           = OUT_W'(noise_r);
        mac_b           = $signed({2'b00, std_r[bank_r]});
      end
      ST_TAP: begin
        mac_ctrl.mul_en  = 1'b1;
        mac_ctrl.acc_exc = (cnt_r == '0);
        mac_ctrl.acc_sub = (cnt_r != '0);
      end
      ST_LAST: begin
        mac_ctrl.acc_sub = 1'b1;
      end
      ST_GAIN: begin
        mac_ctrl.mul_en = 1'b1;
        mac_a           = y_r;
        mac_b           = $signed({2'b00, gain_r});
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    bank_nxt      = bank_r;
    noise_nxt     = noise_r;
    tap_count_nxt = tap_count_r;
    gain_nxt      = gain_r;
    std_nxt       = std_r;
    hist_nxt      = hist_r;
    y_nxt         = y_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_y_nxt     = out_y_r;
    out_drive_nxt = out_drive_r;

    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TAP_COUNT:   tap_count_nxt = cfg_data[TAPC_W-1:0];
        CFG_OUTPUT_GAIN: gain_nxt      = cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          bank_nxt  = in_bank;
          noise_nxt = in_noise_sample;
          if (in_command == CMD_SAMPLE) begin
            state_nxt = ST_EXC;
          end else if (in_command == CMD_STD) begin
            std_nxt[in_bank] = std_load;
          end
        end
      end
      ST_EXC: begin
        cnt_nxt   = '0;
        state_nxt = ST_TAP;
      end
      ST_TAP: begin
        // Rotate the ring so the entry in use always sits at index 0.
        for (int j = 0; j < MAX_TAPS - 1; j++) begin
          hist_nxt[j] = hist_r[j+1];
        end
        hist_nxt[MAX_TAPS-1] = tap_live ? hist_r[0] : '0;
        if (cnt_r == LAST_TAP) begin
          state_nxt = ST_LAST;
        end else begin
          cnt_nxt = cnt_r + IW'(1);
        end
      end
      ST_LAST: begin
        state_nxt = ST_SAT;
      end
      ST_SAT: begin
        y_nxt = y_sat;
        for (int j = MAX_TAPS - 1; j > 0; j--) begin
          hist_nxt[j] = hist_r[j-1];
        end
        hist_nxt[0] = y_sat;
        state_nxt   = ST_GAIN;
      end
      ST_GAIN: begin
        state_nxt = ST_DRV;
      end
      ST_DRV: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_y_nxt     = y_r;
          out_drive_nxt = drive_clamp;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      bank_r      <= 1'b0;
      noise_r     <= '0;
      tap_count_r <= '0;
      gain_r      <= GAIN_RESET;
      std_r[0]    <= '0;
      std_r[1]    <= '0;
      for (int j = 0; j < MAX_TAPS; j++) begin
        hist_r[j] <= '0;
      end
      y_r         <= '0;
      out_valid_r <= 1'b0;
      out_y_r     <= '0;
      out_drive_r <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      bank_r      <= bank_nxt;
      noise_r     <= noise_nxt;
      tap_count_r <= tap_count_nxt;
      gain_r      <= gain_nxt;
      std_r       <= std_nxt;
      hist_r      <= hist_nxt;
      y_r         <= y_nxt;
      out_valid_r <= out_valid_nxt;
      out_y_r     <= out_y_nxt;
      out_drive_r <= out_drive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (coef_wr) begin
      coef_mem[wr_addr] <= in_load_value;
    end
    coef_rd_r     <= coef_mem[rd_addr];
    coef_vld_rd_r <= coef_vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0;
    end else if (coef_wr) begin
      coef_vld_r[wr_addr] <= 1'b1;
    end
  end

endmodule

/* rtl/artvs_checker.sv */
// Port-level checks for the AR texture vibration synthesizer, bound to the top.
// Depends on artvs_pkg for widths and command codes.
module artvs_checker import artvs_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [CMD_W-1:0]          in_command,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [OUT_W-1:0]   out_filter_output,
  input logic signed [DRIVE_W-1:0] out_drive_value
);

  // A sample keeps the block busy on the following cycle.
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command == CMD_SAMPLE |=> in_stall)
    else $error("sample transfer did not make the block busy");

  // Writes and dropped commands leave the input channel free on the next cycle.
  a_write_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command != CMD_SAMPLE |=> !in_stall)
    else $error("write item held the input channel");

  // A new result only appears at the end of a sample computation.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a sample in progress");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drive_value <= 16'sd20480) && (out_drive_value >= -16'sd20480))
    else $error("drive value outside the clamp range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_filter_output)
      && $stable(out_drive_value))
    else $error("stalled result changed");

endmodule

bind ar_texture_vibration_synth artvs_checker u_artvs_checker (.*);

/* verif/tb_ar_texture_vibration_synth.sv */
`timescale 1ns / 1ps
// Self-checking testbench for ar_texture_vibration_synth: directed and random
// sample and parameter-write transfers, checked against a behavioral AR synthesizer.
// Depends on artvs_pkg and the RTL of the block.
module tb_ar_texture_vibration_synth;
  import artvs_pkg::*;

  localparam int NUM_TAPS = 16;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_PCT = 13;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 100;
  localparam longint ACCEL_MAX = 64'sd2147483647;
  localparam longint ACCEL_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic                bank;
    logic [TAPIDX_W-1:0] tap;
    logic [COEF_W-1:0]   load;
    logic [NOISE_W-1:0]  noise;
  } synth_cmd_t;

  typedef struct packed {
    logic [OUT_W-1:0]   accel;
    logic [DRIVE_W-1:0] drive;
  } synth_out_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [CMD_W-1:0]           in_command = '0;
  logic                       in_bank = 1'b0;
  logic [TAPIDX_W-1:0]        in_tap_index = '0;
  logic signed [COEF_W-1:0]   in_load_value = '0;
  logic signed [NOISE_W-1:0]  in_noise_sample = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [OUT_W-1:0]    out_filter_output;
  logic signed [DRIVE_W-1:0]  out_drive_value;

  // Behavioral copy of the synthesizer state and registers.
  longint                    accel_hist[NUM_TAPS];
  logic signed [COEF_W-1:0]  ar_coef[2*NUM_TAPS];
  logic [STD_W-1:0]          noise_std[2];
  logic [TAPC_W-1:0]         tap_count_m = '0;
  logic [GAIN_W-1:0]         gain_m = GAIN_RESET;

  synth_cmd_t pending_cmds[$];
  synth_out_t expected_outs[$];
  synth_cmd_t next_cmd;
  synth_cmd_t seen_cmd;
  synth_out_t exp_out;

  logic in_took = 1'b0;
  logic calm = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  int n_queued = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_coef_writes = 0;
  int n_std_writes = 0;
  int n_ignored = 0;
  int n_settings = 0;
  int n_err = 0;

  ar_texture_vibration_synth dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_bank           (in_bank),
    .in_tap_index      (in_tap_index),
    .in_load_value     (in_load_value),
    .in_noise_sample   (in_noise_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_filter_output (out_filter_output),
    .out_drive_value   (out_drive_value)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Applies one accepted transfer to the behavioral state and queues the
  // result that a sample produces.
  task automatic synthesize(input synth_cmd_t c);
    int n;
    longint acc;
    longint y;
    longint drv;
    synth_out_t r;
    case (c.cmd)
      CMD_COEF: begin
        ar_coef[c.bank * NUM_TAPS + c.tap] = c.load;
        n_coef_writes++;
      end
      CMD_STD: begin
        if ($signed(c.load) < 0) noise_std[c.bank] = '0;
        else if ($signed(c.load) > STD_MAX) noise_std[c.bank] = '1;
        else noise_std[c.bank] = c.load[STD_W-1:0];
        n_std_writes++;
      end
      CMD_SAMPLE: begin
        n = (tap_count_m > NUM_TAPS) ? NUM_TAPS : int'(tap_count_m);
        // Excitation widened to 28 fraction bits, like each AR term.
        acc = longint'($signed(c.noise)) * longint'(noise_std[c.bank]) * 256;
        for (int i = 0; i < n; i++)
          acc -= accel_hist[i] * longint'(ar_coef[c.bank * NUM_TAPS + i]);
        y = acc >>> Y_SHIFT;
        if (y > ACCEL_MAX) y = ACCEL_MAX;
        if (y < ACCEL_MIN) y = ACCEL_MIN;
        for (int i = n; i < NUM_TAPS; i++) accel_hist[i] = 0;
        for (int i = NUM_TAPS - 1; i > 0; i--) accel_hist[i] = accel_hist[i-1];
        accel_hist[0] = y;
        drv = (y * longint'(gain_m)) >>> DRIVE_SHIFT;
        if (drv > DRIVE_LIMIT) drv = DRIVE_LIMIT;
        if (drv < -DRIVE_LIMIT) drv = -DRIVE_LIMIT;
        r.accel = y[OUT_W-1:0];
        r.drive = drv[DRIVE_W-1:0];
        expected_outs = {expected_outs, r};
      end
      default: n_ignored++;
    endcase
  endtask

  task automatic note_mismatch(input string field, input logic signed [OUT_W-1:0] exp_v,
                               input logic signed [OUT_W-1:0] act_v);
    if (n_err < 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, exp_v, act_v);
    n_err++;
  endtask

  task automatic add_item(input logic [CMD_W-1:0] cmd, input logic bank,
                          input logic [TAPIDX_W-1:0] tap, input int load, input int noise);
    synth_cmd_t c;
    c.cmd = cmd;
    c.bank = bank;
    c.tap = tap;
    c.load = load[COEF_W-1:0];
    c.noise = noise[NOISE_W-1:0];
    pending_cmds = {pending_cmds, c};
    n_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_TAP_COUNT) tap_count_m = val[TAPC_W-1:0];
    else gain_m = val;
    n_settings++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Waits until every queued item is taken and every result has arrived, then
  // lets the block finish any trailing write before the next register change.
  task automatic settle();
    while (n_accepted != n_queued || expected_outs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int small_coef(input int taps);
    int lim;
    // Keeps the sum of coefficient magnitudes below 0.75 so the filter stays stable.
    lim = 3000 / (taps + 1);
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  function automatic int wide_noise();
    if ($urandom_range(3) == 0) return int'($urandom);
    return int'($urandom_range(8191)) - 4096;
  endfunction

  // Sender: a new item goes out only after the previous one was transferred.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (pending_cmds.size() != 0 && !(!calm && $urandom_range(99) < IDLE_PCT)) begin
        next_cmd = pending_cmds.pop_front();
        in_valid <= 1'b1;
        in_command <= next_cmd.cmd;
        in_bank <= next_cmd.bank;
        in_tap_index <= next_cmd.tap;
        in_load_value <= next_cmd.load;
        in_noise_sample <= next_cmd.noise;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off when requested.
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (expected_outs.size() == 0) begin
          if (n_err < 10)
            $display("%0t: unexpected result %0d / %0d", $realtime,
                     out_filter_output, out_drive_value);
          n_err++;
        end else begin
          exp_out = expected_outs.pop_front();
          if (out_filter_output !== exp_out.accel)
            note_mismatch("filter_output", exp_out.accel, out_filter_output);
          if (out_drive_value !== exp_out.drive)
            note_mismatch("drive_value", OUT_W'($signed(exp_out.drive)),
                          OUT_W'(out_drive_value));
          n_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        seen_cmd.cmd = in_command;
        seen_cmd.bank = in_bank;
        seen_cmd.tap = in_tap_index;
        seen_cmd.load = in_load_value;
        seen_cmd.noise = in_noise_sample;
        n_accepted++;
        synthesize(seen_cmd);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int tap_plan[NUM_PHASES];
    int gain_plan[NUM_PHASES];
    int ntaps;
    int r;
    logic act_bank;
    logic bank;

    for (int i = 0; i < NUM_TAPS; i++) accel_hist[i] = 0;
    for (int i = 0; i < 2 * NUM_TAPS; i++) ar_coef[i] = '0;
    noise_std[0] = '0;
    noise_std[1] = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: no taps, gain 8.0. Standard deviation clipping both ways.
    add_item(CMD_SAMPLE, 1'b0, 4'd15, 131071, 32767);
    add_item(CMD_STD, 1'b0, 4'd0, -5, 0);
    add_item(CMD_STD, 1'b1, 4'd0, 131071, 0);
    add_item(CMD_SAMPLE, 1'b1, 4'd0, -131072, -32768);
    add_item(CMD_SAMPLE, 1'b1, 4'd5, 0, 32767);
    add_item(CMD_STD, 1'b0, 4'd3, 256, 0);
    add_item(CMD_SAMPLE, 1'b0, 4'd10, 0, 4096);
    add_item(CMD_UNUSED, 1'b1, 4'd15, 131071, -1);
    settle();

    // Tap count above the history depth, full gain, extreme coefficients.
    write_reg(CFG_TAP_COUNT, 16'd31);
    write_reg(CFG_OUTPUT_GAIN, 16'hFFFF);
    add_item(CMD_COEF, 1'b0, 4'd0, 131071, 0);
    add_item(CMD_COEF, 1'b0, 4'd15, -131072, 0);
    add_item(CMD_COEF, 1'b1, 4'd7, -4096, 0);
    add_item(CMD_COEF, 1'b1, 4'd0, 2048, 0);
    add_item(CMD_SAMPLE, 1'b0, 4'd0, 0, 32767);
    add_item(CMD_SAMPLE, 1'b0, 4'd1, 0, -32768);
    add_item(CMD_SAMPLE, 1'b0, 4'd2, 0, 0);
    add_item(CMD_SAMPLE, 1'b0, 4'd3, 0, 1);
    add_item(CMD_SAMPLE, 1'b0, 4'd4, 0, -1);
    add_item(CMD_SAMPLE, 1'b1, 4'd8, 0, 32767);
    add_item(CMD_SAMPLE, 1'b1, 4'd9, 0, -32768);
    settle();

    write_reg(CFG_TAP_COUNT, 16'd16);
    write_reg(CFG_OUTPUT_GAIN, 16'd0);
    add_item(CMD_SAMPLE, 1'b0, 4'd12, 0, 12345);
    add_item(CMD_SAMPLE, 1'b1, 4'd6, 0, -23456);

    tap_plan = '{0, 16, 31, 1, 4, 8, 0, 0};
    gain_plan = '{0, 65535, 2048, 256, 512, 1024, 0, 0};
    tap_plan[6] = $urandom_range(31);
    tap_plan[7] = $urandom_range(31);
    gain_plan[6] = $urandom_range(65535);
    gain_plan[7] = $urandom_range(65535);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      // Upper data bits above the tap count field carry random junk.
      write_reg(CFG_TAP_COUNT, {11'($urandom_range(2047)), tap_plan[ph][TAPC_W-1:0]});
      write_reg(CFG_OUTPUT_GAIN, gain_plan[ph][GAIN_W-1:0]);
      calm = (ph == 2);
      if (ph == 5) hold_req = 1'b1;
      ntaps = (tap_plan[ph] > NUM_TAPS) ? NUM_TAPS : tap_plan[ph];
      act_bank = 1'($urandom_range(1));

      // Load a stable model into the active bank, then mostly run samples on it.
      add_item(CMD_STD, act_bank, TAPIDX_W'($urandom), $urandom_range(64, 768), $urandom);
      for (int t = 0; t < ntaps; t++)
        add_item(CMD_COEF, act_bank, t[TAPIDX_W-1:0], small_coef(ntaps), $urandom);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(99);
        bank = ($urandom_range(9) < 8) ? act_bank : !act_bank;
        if (r < 65) begin
          add_item(CMD_SAMPLE, bank, TAPIDX_W'($urandom), $urandom, wide_noise());
        end else if (r < 82) begin
          if ($urandom_range(9) == 0)
            add_item(CMD_COEF, bank, TAPIDX_W'($urandom), $urandom, $urandom);
          else
            add_item(CMD_COEF, bank, TAPIDX_W'($urandom), small_coef(ntaps), $urandom);
        end else if (r < 92) begin
          if ($urandom_range(4) == 0)
            add_item(CMD_STD, bank, TAPIDX_W'($urandom), $urandom, $urandom);
          else
            add_item(CMD_STD, bank, TAPIDX_W'($urandom), $urandom_range(768), $urandom);
        end else begin
          add_item(CMD_UNUSED, bank, TAPIDX_W'($urandom), $urandom, $urandom);
        end
      end
    end

    settle();
    calm = 1'b0;
    $display("Checked %0d results from %0d input transfers: %0d coefficient writes,",
             n_checked, n_accepted, n_coef_writes);
    $display("%0d std dev writes, %0d ignored, %0d register writes, %0d-cycle output hold.",
             n_std_writes, n_ignored, n_settings, HOLD_CYCLES);
    if (n_err == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
